FILE: hw/rtl/i2cram_pkg.sv
// shared types, codes and constants of the i2c register access master
`default_nettype none
package i2cram_pkg;

  // write buffer geometry
  localparam int WBUF_DEPTH = 16;
  localparam int WBUF_AW    = $clog2(WBUF_DEPTH);

  // item opcodes
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_LOAD     = 2'd1;
  localparam logic [1:0] OP_START_WR = 2'd2;
  localparam logic [1:0] OP_START_RD = 2'd3;

  // sequencer phases
  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_ST_A    = 5'd1;
  localparam logic [4:0] PH_ST_B    = 5'd2;
  localparam logic [4:0] PH_ST_C    = 5'd3;
  localparam logic [4:0] PH_TX_D    = 5'd4;
  localparam logic [4:0] PH_TX_H    = 5'd5;
  localparam logic [4:0] PH_TX_L    = 5'd6;
  localparam logic [4:0] PH_AK_R    = 5'd7;
  localparam logic [4:0] PH_AK_H    = 5'd8;
  localparam logic [4:0] PH_AK_S    = 5'd9;
  localparam logic [4:0] PH_AK_NEXT = 5'd10;
  localparam logic [4:0] PH_ABORT   = 5'd11;
  localparam logic [4:0] PH_RX_REL  = 5'd12;
  localparam logic [4:0] PH_RX_H    = 5'd13;
  localparam logic [4:0] PH_RX_S    = 5'd14;
  localparam logic [4:0] PH_RX_W    = 5'd15;
  localparam logic [4:0] PH_RX_A    = 5'd16;
  localparam logic [4:0] PH_RX_AH   = 5'd17;
  localparam logic [4:0] PH_RX_AL   = 5'd18;
  localparam logic [4:0] PH_RX_END  = 5'd19;
  localparam logic [4:0] PH_SP_A    = 5'd20;
  localparam logic [4:0] PH_SP_B    = 5'd21;

  // byte being sent within a transaction
  localparam logic [1:0] STG_ADDR  = 2'd0;
  localparam logic [1:0] STG_REG   = 2'd1;
  localparam logic [1:0] STG_DATA  = 2'd2;
  localparam logic [1:0] STG_RADDR = 2'd3;

  localparam logic [7:0] RD_BIT   = 8'h01;
  localparam logic [3:0] LAST_BIT = 4'd7;

  // one input item
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  address_byte;
    logic [7:0]  register_address;
    logic [15:0] byte_count;
    logic [7:0]  write_data;
    logic [3:0]  buffer_index;
    logic        sda_in;
  } i2cram_item_t;

  // one result item
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       success;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
  } i2cram_res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/i2cram_wbuf.sv
// write data buffer: one write port from load items, one read port for the sequencer
`default_nettype none
module i2cram_wbuf
  import i2cram_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [WBUF_AW-1:0] wr_addr,
  input  wire logic [7:0]         wr_data,
  input  wire logic [WBUF_AW-1:0] rd_addr,
  output logic      [7:0]         rd_data
);

  logic [7:0] mem_r [WBUF_DEPTH];
  logic [7:0] rd_data_r;

  // slot write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered slot read, a write to the same slot passes straight through
  // the pointer settles many items before the sequencer uses the byte
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: hw/rtl/i2cram_seq.sv
// bus sequencer: state registers and the single-step next-state logic
`default_nettype none
module i2cram_seq
  import i2cram_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_en,
  input  wire i2cram_item_t       item,
  input  wire logic [7:0]         tpd,
  output logic      [WBUF_AW-1:0] buf_rd_addr,
  input  wire logic [7:0]         buf_rd_data,
  output i2cram_res_t             res
);

  logic [4:0]         phase_r, phase_nxt;
  logic [3:0]         bit_cnt_r, bit_cnt_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [15:0]        bytes_left_r, bytes_left_nxt;
  logic [WBUF_AW-1:0] byte_ptr_r, byte_ptr_nxt;
  logic [7:0]         delay_r, delay_nxt;
  logic               is_read_r, is_read_nxt;
  logic [7:0]         saddr_r, saddr_nxt;
  logic [7:0]         sreg_r, sreg_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic [1:0]         stage_r, stage_nxt;

  logic [4:0] ph;
  logic       do_step;
  logic       set_dly;
  logic       sda_s;
  logic [7:0] tpd_eff;

  assign buf_rd_addr = byte_ptr_r;
  assign tpd_eff     = (tpd == 8'd0) ? 8'd1 : tpd;

  // next state for one item
  always_comb begin
    phase_nxt      = phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    bytes_left_nxt = bytes_left_r;
    byte_ptr_nxt   = byte_ptr_r;
    delay_nxt      = delay_r;
    is_read_nxt    = is_read_r;
    saddr_nxt      = saddr_r;
    sreg_nxt       = sreg_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    stage_nxt      = stage_r;
    res            = '0;
    ph             = phase_r;
    do_step        = 1'b0;
    set_dly        = 1'b1;
    sda_s          = item.sda_in;

    // item decode
    case (item.opcode)
      OP_TICK: begin
        if (phase_r != PH_IDLE) begin
          if (delay_r > 8'd1) begin
            delay_nxt = delay_r - 8'd1;
          end else begin
            delay_nxt = 8'd0;
            do_step   = 1'b1;
          end
        end
      end
      OP_START_WR, OP_START_RD: begin
        if (phase_r == PH_IDLE) begin
          is_read_nxt    = (item.opcode == OP_START_RD);
          saddr_nxt      = item.address_byte;
          sreg_nxt       = item.register_address;
          bytes_left_nxt = (is_read_nxt && item.byte_count == 16'd0) ? 16'd1
                                                                      : item.byte_count;
          byte_ptr_nxt   = '0;
          bit_cnt_nxt    = 4'd0;
          stage_nxt      = STG_ADDR;
          ph             = PH_ST_A;
          do_step        = 1'b1;
          sda_s          = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (do_step) begin
      // zero-delay hand-over phases chain into the following step
      if (ph == PH_AK_NEXT) begin
        if (stage_nxt == STG_ADDR) begin
          stage_nxt   = STG_REG;
          shift_nxt   = sreg_nxt;
          bit_cnt_nxt = 4'd0;
          ph          = PH_TX_D;
        end else if (stage_nxt == STG_REG && is_read_nxt) begin
          stage_nxt = STG_RADDR;
          ph        = PH_ST_A;
        end else if (stage_nxt == STG_RADDR) begin
          ph = PH_RX_REL;
        end else if (bytes_left_nxt != 16'd0) begin
          stage_nxt      = STG_DATA;
          shift_nxt      = buf_rd_data;
          bit_cnt_nxt    = 4'd0;
          ph             = PH_TX_D;
          byte_ptr_nxt   = byte_ptr_nxt + WBUF_AW'(1);
          bytes_left_nxt = bytes_left_nxt - 16'd1;
        end else begin
          ph = PH_SP_A;
        end
      end else if (ph == PH_RX_END) begin
        sda_nxt = 1'b1;
        if (bytes_left_nxt != 16'd0) begin
          bytes_left_nxt = bytes_left_nxt - 16'd1;
        end
        ph = (bytes_left_nxt != 16'd0) ? PH_RX_REL : PH_SP_A;
      end

      // one bus step
      case (ph)
        PH_ST_A: begin
          sda_nxt   = 1'b1;
          scl_nxt   = 1'b1;
          phase_nxt = PH_ST_B;
        end
        PH_ST_B: begin
          sda_nxt   = 1'b0;
          phase_nxt = PH_ST_C;
        end
        PH_ST_C: begin
          scl_nxt     = 1'b0;
          shift_nxt   = (stage_nxt == STG_RADDR) ? (saddr_nxt | RD_BIT) : saddr_nxt;
          bit_cnt_nxt = 4'd0;
          phase_nxt   = PH_TX_D;
        end
        PH_TX_D: begin
          sda_nxt   = shift_nxt[7];
          phase_nxt = PH_TX_H;
        end
        PH_TX_H: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_TX_L;
        end
        PH_TX_L: begin
          scl_nxt = 1'b0;
          if (bit_cnt_nxt == LAST_BIT) begin
            sda_nxt = 1'b1;
          end
          phase_nxt   = (bit_cnt_nxt == LAST_BIT) ? PH_AK_R : PH_TX_D;
          shift_nxt   = {shift_nxt[6:0], 1'b0};
          bit_cnt_nxt = bit_cnt_nxt + 4'd1;
        end
        PH_AK_R: begin
          sda_nxt   = 1'b1;
          phase_nxt = PH_AK_H;
        end
        PH_AK_H: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_AK_S;
        end
        PH_AK_S: begin
          scl_nxt   = 1'b0;
          phase_nxt = sda_s ? PH_ABORT : PH_AK_NEXT;
        end
        PH_ABORT: begin
          res.done_res = 1'b1;
          phase_nxt    = PH_IDLE;
          set_dly      = 1'b0;
        end
        PH_RX_REL: begin
          sda_nxt     = 1'b1;
          shift_nxt   = 8'd0;
          bit_cnt_nxt = 4'd0;
          phase_nxt   = PH_RX_H;
        end
        PH_RX_H: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_RX_S;
        end
        PH_RX_S: begin
          scl_nxt = 1'b0;
          shift_nxt = {shift_nxt[6:0], sda_s};
          if (bit_cnt_nxt == LAST_BIT) begin
            res.read_valid = 1'b1;
            res.read_data  = shift_nxt;
            res.read_last  = (bytes_left_nxt <= 16'd1);
            phase_nxt      = PH_RX_W;
          end else begin
            phase_nxt = PH_RX_H;
          end
          bit_cnt_nxt = bit_cnt_nxt + 4'd1;
        end
        PH_RX_W: begin
          phase_nxt = PH_RX_A;
        end
        PH_RX_A: begin
          sda_nxt   = (bytes_left_nxt <= 16'd1);
          phase_nxt = PH_RX_AH;
        end
        PH_RX_AH: begin
          scl_nxt   = 1'b1;
          phase_nxt = PH_RX_AL;
        end
        PH_RX_AL: begin
          scl_nxt   = 1'b0;
          phase_nxt = PH_RX_END;
        end
        PH_SP_A: begin
          sda_nxt   = 1'b0;
          scl_nxt   = 1'b1;
          phase_nxt = PH_SP_B;
        end
        PH_SP_B: begin
          sda_nxt       = 1'b1;
          res.done_res  = 1'b1;
          res.success   = 1'b1;
          phase_nxt     = PH_IDLE;
          set_dly       = 1'b0;
        end
        default: begin
          phase_nxt = PH_IDLE;
          set_dly   = 1'b0;
        end
      endcase

      if (set_dly) begin
        delay_nxt = tpd_eff;
      end
    end

    res.scl_out  = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = (phase_nxt != PH_IDLE);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_cnt_r    <= 4'd0;
      shift_r      <= 8'd0;
      bytes_left_r <= 16'd0;
      byte_ptr_r   <= '0;
      delay_r      <= 8'd0;
      is_read_r    <= 1'b0;
      saddr_r      <= 8'd0;
      sreg_r       <= 8'd0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      stage_r      <= STG_ADDR;
    end else if (item_en) begin
      phase_r      <= phase_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      shift_r      <= shift_nxt;
      bytes_left_r <= bytes_left_nxt;
      byte_ptr_r   <= byte_ptr_nxt;
      delay_r      <= delay_nxt;
      is_read_r    <= is_read_nxt;
      saddr_r      <= saddr_nxt;
      sreg_r       <= sreg_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      stage_r      <= stage_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/i2c_register_access_master_core.sv
// Bit-banged I2C master for register writes and reads, driven by a stream of items.
// Every accepted item (tick, buffer load or start command) yields exactly one result
// item carrying the SCL/SDA drive levels and status. The block takes one item per
// clock; the result is written into the output register on acceptance, and
// in_tready stays high as long as that register is empty or being drained. Bus timing
// is set only by tick items: each pin change is held for cfg_data tick items (zero
// counts as one). A write sends address, register and byte_count bytes from the
// 16-entry buffer; a read sends address, register, a repeated start and address|1,
// then returns each received byte with out_tuser set and out_tlast on the final one.
`default_nettype none
module i2c_register_access_master_core
  import i2cram_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // address_byte[7:0], register_address[15:8], byte_count[31:16], write_data[39:32],
  // buffer_index[43:40], sda_in[44], zero[47:45]
  input  wire logic [47:0] in_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  in_tuser,
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], success[4], read_data[12:5],
  // zero[15:13]
  output logic      [15:0] out_tdata,
  // read_valid[0]
  output logic             out_tuser,
  output logic             out_tlast,
  // ticks per delay register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  i2cram_item_t       item;
  i2cram_res_t        res;
  logic               in_acc;
  logic [7:0]         tpd_r;
  logic               out_tvalid_r;
  i2cram_res_t        res_r;
  logic [WBUF_AW-1:0] buf_rd_addr;
  logic [7:0]         buf_rd_data;
  logic               buf_wr_en;

  // input unpacking
  assign item.opcode           = in_tuser;
  assign item.address_byte     = in_tdata[7:0];
  assign item.register_address = in_tdata[15:8];
  assign item.byte_count       = in_tdata[31:16];
  assign item.write_data       = in_tdata[39:32];
  assign item.buffer_index     = in_tdata[43:40];
  assign item.sda_in           = in_tdata[44];

  // handshake
  assign in_tready = !out_tvalid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpd_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      tpd_r <= cfg_data;
    end
  end

  // buffer load
  assign buf_wr_en = in_acc && (item.opcode == OP_LOAD)
                     && ({1'b0, item.buffer_index} < 5'(WBUF_DEPTH));

  i2cram_wbuf u_wbuf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (item.buffer_index[WBUF_AW-1:0]),
    .wr_data (item.write_data),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rd_data)
  );

  i2cram_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_en     (in_acc),
    .item        (item),
    .tpd         (tpd_r),
    .buf_rd_addr (buf_rd_addr),
    .buf_rd_data (buf_rd_data),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (in_acc) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  // output packing
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, res_r.read_data, res_r.success, res_r.done_res,
                       res_r.busy_res, res_r.sda_out, res_r.scl_out};
  assign out_tuser  = res_r.read_valid;
  assign out_tlast  = res_r.read_last;

  // checks
  a_acc_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_tvalid_r)
    else $error("accepted item gave no result");

  a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && res_r.read_last |-> res_r.read_valid)
    else $error("last flag without a received byte");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && res_r.done_res |-> !res_r.busy_res && !res_r.read_valid)
    else $error("done reported while still busy or receiving");

endmodule
`default_nettype wire
